[src/usc_pkg.sv]
// Package for the sorted unique connection set: sizes, command and status
// codes, controller states and the per-cell control struct. No dependencies.
package usc_pkg;

  localparam int CAPACITY = 64;
  localparam int NET_W    = 16;
  localparam int COMP_W   = 16;
  localparam int TERM_W   = 8;
  localparam int KEY_W    = NET_W + COMP_W + TERM_W;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_EMIT   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMITTED   = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_EMIT,
    S_SINGLE
  } state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic capture;  // latch compare flags against the incoming key
    logic insert;   // open a slot and shift the upper part up by one
    logic rotate;   // shift down by one, head entry wraps to the tail
  } cell_ctrl_t;

endpackage

[src/unique_connection_sorted_set.sv]
// An insert compares in the accept cycle; S_INSERT loads its result and, for a
// new key with room, opens its slot. Clear and empty emit load from S_SINGLE. An
// N-record emit gives one record per cycle while the output register is free,
// and holds the input (ready only in S_IDLE) until the chain has rotated once.
// Reset: rst is synchronous, active high; clears the record count and control.
// Key storage has no reset; entries beyond the count are never read.
module unique_connection_sorted_set (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // command[1:0], net_index[17:2], component_index[33:18],
  // terminal_code[41:34], zero[47:42]
  input  logic [usc_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status[2:0], out_net[18:3], out_component[34:19],
  // out_terminal[42:35], zero[47:43]
  output logic [usc_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast
);

  localparam int CAP = usc_pkg::CAPACITY;
  localparam int KW  = usc_pkg::KEY_W;
  localparam int CW  = usc_pkg::CNT_W;

  // ---------------------------------------------------------------------
  // Input unpacking. The key orders net over component over terminal.
  // ---------------------------------------------------------------------
  usc_pkg::cmd_t   in_cmd;
  logic [KW-1:0]   in_key;

  assign in_cmd = usc_pkg::cmd_t'(s_tdata[1:0]);
  assign in_key = {s_tdata[17:2], s_tdata[33:18], s_tdata[41:34]};

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  usc_pkg::state_t   state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic [KW-1:0]     key_q;
  usc_pkg::status_t  single_status, single_status_next;

  usc_pkg::cell_ctrl_t cell_ctrl;

  // Cell chain signals
  logic [KW-1:0]   cell_key [CAP];
  logic [CAP-1:0]  cell_gt;
  logic [CAP-1:0]  cell_eq;
  logic [CAP-1:0]  occ;

  logic dup;
  logic full;
  logic out_free;
  logic accept;

  // Output load request
  logic              load;
  usc_pkg::status_t  load_status;
  logic [KW-1:0]     load_key;
  logic              load_last;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = (state == usc_pkg::S_IDLE);
  assign out_free = ~m_tvalid | m_tready;
  assign dup      = |cell_eq;
  assign full     = (count == CW'(CAP));

  // ---------------------------------------------------------------------
  // Cell chain. Occupancy is a thermometer built from the count; the held
  // entries stay sorted ascending from cell 0.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [KW-1:0] prev_key;
    logic [KW-1:0] next_key;
    logic          prev_gt;
    logic          prev_occ;
    logic          next_occ;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign prev_key = key_q;
      assign prev_gt  = 1'b0;
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
      assign prev_gt  = cell_gt[i-1];
      assign prev_occ = occ[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign next_key = cell_key[0];
      assign next_occ = 1'b0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_occ = occ[i+1];
    end

    usc_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .cmp_key   (in_key),
      .new_key   (key_q),
      .prev_key  (prev_key),
      .next_key  (next_key),
      .first_key (cell_key[0]),
      .prev_gt   (prev_gt),
      .prev_occ  (prev_occ),
      .occ       (occ[i]),
      .next_occ  (next_occ),
      .key       (cell_key[i]),
      .gt        (cell_gt[i]),
      .eq        (cell_eq[i])
    );
  end

  // ---------------------------------------------------------------------
  // State register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= usc_pkg::S_IDLE;
      count         <= '0;
      idx           <= '0;
      single_status <= usc_pkg::STAT_CLEARED;
    end else begin
      state         <= state_next;
      count         <= count_next;
      idx           <= idx_next;
      single_status <= single_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= in_key;
    end
  end

  // ---------------------------------------------------------------------
  // Next state and chain control
  // ---------------------------------------------------------------------
  always_comb begin
    state_next         = state;
    count_next         = count;
    idx_next           = idx;
    single_status_next = single_status;
    cell_ctrl          = '0;
    load               = 1'b0;
    load_status        = usc_pkg::STAT_INSERTED;
    load_key           = '0;
    load_last          = 1'b1;

    unique case (state)
      usc_pkg::S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_cmd)
            usc_pkg::CMD_INSERT: begin
              // cells compare against the port key in the accept cycle
              cell_ctrl.capture = 1'b1;
              state_next        = usc_pkg::S_INSERT;
            end
            usc_pkg::CMD_EMIT: begin
              if (count == '0) begin
                single_status_next = usc_pkg::STAT_EMPTY;
                state_next         = usc_pkg::S_SINGLE;
              end else begin
                idx_next   = '0;
                state_next = usc_pkg::S_EMIT;
              end
            end
            usc_pkg::CMD_CLEAR: begin
              count_next         = '0;
              single_status_next = usc_pkg::STAT_CLEARED;
              state_next         = usc_pkg::S_SINGLE;
            end
            default: begin
              // unused code: dropped without a result
            end
          endcase
        end
      end

      usc_pkg::S_INSERT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = usc_pkg::S_IDLE;
          if (dup) begin
            load_status = usc_pkg::STAT_DUPLICATE;
          end else if (full) begin
            load_status = usc_pkg::STAT_FULL;
          end else begin
            load_status      = usc_pkg::STAT_INSERTED;
            cell_ctrl.insert = 1'b1;
            count_next       = count + CW'(1);
          end
        end
      end

      usc_pkg::S_EMIT: begin
        if (out_free) begin
          // head of the chain goes out and wraps to the tail, so after
          // count steps the order is back where it started
          load             = 1'b1;
          load_status      = usc_pkg::STAT_EMITTED;
          load_key         = cell_key[0];
          load_last        = ((idx + CW'(1)) == count);
          cell_ctrl.rotate = 1'b1;
          idx_next         = idx + CW'(1);
          if (load_last) begin
            state_next = usc_pkg::S_IDLE;
          end
        end
      end

      usc_pkg::S_SINGLE: begin
        if (out_free) begin
          load        = 1'b1;
          load_status = single_status;
          state_next  = usc_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = usc_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register: holds one transaction; the next input can be accepted while
  // it waits to be taken, but no new result loads until it is free.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {5'd0,
                  load_key[usc_pkg::TERM_W-1:0],
                  load_key[usc_pkg::TERM_W +: usc_pkg::COMP_W],
                  load_key[usc_pkg::TERM_W + usc_pkg::COMP_W +: usc_pkg::NET_W],
                  load_status};
      m_tlast <= load_last;
    end
  end

`ifndef NO_ASSERTIONS
  // The record count never goes past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP))
    else $error("record count above capacity");

  // A clear empties the table by the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == usc_pkg::CMD_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

  // Every result other than an emitted record ends its run.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != usc_pkg::STAT_EMITTED) |-> m_tlast)
    else $error("non-record result without last");

  // An emit leaves the table size untouched.
  a_emit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == usc_pkg::S_EMIT) |=> $stable(count))
    else $error("count changed during emit");
`endif

endmodule

[src/usc_cell.sv]
// One cell of the sorted key chain: a key register plus compare flags.
// Depends on usc_pkg.
module usc_cell (
  input  logic                       clk,
  input  usc_pkg::cell_ctrl_t        ctrl,
  input  logic [usc_pkg::KEY_W-1:0]  cmp_key,   // key from the input port
  input  logic [usc_pkg::KEY_W-1:0]  new_key,   // latched key to insert
  input  logic [usc_pkg::KEY_W-1:0]  prev_key,
  input  logic [usc_pkg::KEY_W-1:0]  next_key,
  input  logic [usc_pkg::KEY_W-1:0]  first_key,
  input  logic                       prev_gt,
  input  logic                       prev_occ,
  input  logic                       occ,
  input  logic                       next_occ,
  output logic [usc_pkg::KEY_W-1:0]  key,
  output logic                       gt,
  output logic                       eq
);

  logic gt_q;
  logic eq_q;
  logic head;
  logic tail;
  logic take;

  assign gt   = gt_q & occ;
  assign eq   = eq_q & occ;
  assign head = prev_occ & ~occ;       // first free slot
  assign tail = occ & ~next_occ;       // last held entry
  assign take = gt | head;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      gt_q <= (key > cmp_key);
      eq_q <= (key == cmp_key);
    end
    if (ctrl.insert && take) begin
      key <= prev_gt ? prev_key : new_key;
    end else if (ctrl.rotate) begin
      key <= tail ? first_key : next_key;
    end
  end

endmodule

[test/tb_unique_connection_sorted_set.sv]
// Testbench for unique_connection_sorted_set: drives insert/emit/clear and unused-code
// transactions with random gaps and stalls, predicts results with a sorted key queue.
// Depends on usc_pkg and the unique_connection_sorted_set RTL only.
module tb_unique_connection_sorted_set;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 has no meaning; the block must drop it without a result.
  localparam logic [usc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_WAIT     = 11;
  localparam int TOTAL_ITEMS  = 230;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [usc_pkg::CMD_W-1:0]  cmd;
    logic [usc_pkg::NET_W-1:0]  net;
    logic [usc_pkg::COMP_W-1:0] comp;
    logic [usc_pkg::TERM_W-1:0] term;
  } conn_item_t;

  typedef struct packed {
    usc_pkg::status_t           status;
    logic [usc_pkg::NET_W-1:0]  net;
    logic [usc_pkg::COMP_W-1:0] comp;
    logic [usc_pkg::TERM_W-1:0] term;
    logic                       last;
  } conn_result_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic [usc_pkg::IN_W-1:0]   s_tdata  = '0;
  logic                       m_tready = 1'b0;
  logic                       s_tready;
  logic                       m_tvalid;
  logic [usc_pkg::OUT_W-1:0]  m_tdata;
  logic                       m_tlast;

  unique_connection_sorted_set DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending transactions, the predicted results in order, and the predicted
  // contents of the set kept in ascending key order.
  conn_item_t                pending_items[$];
  conn_result_t              expected_results[$];
  logic [usc_pkg::KEY_W-1:0] held_keys[$];
  logic [usc_pkg::KEY_W-1:0] used_keys[$];   // inserted keys, reused to force duplicates

  conn_item_t   driven_item;
  conn_result_t got, want;
  int  items_total     = 0;
  int  items_accepted  = 0;
  int  results_checked = 0;
  int  faults          = 0;
  int  reported        = 0;
  int  status_hits[8];
  int  in_gap     = 0;
  int  out_stall  = 0;
  bit  in_burst   = 1'b0;
  bit  out_burst  = 1'b0;
  bit  in_taken   = 1'b0;
  bit  out_taken  = 1'b0;

  // Apply one accepted transaction to the predicted set and queue its results.
  function automatic void predict_set_update(conn_item_t it);
    logic [usc_pkg::KEY_W-1:0] key;
    conn_result_t              r;
    int                        pos;
    bit                        dup;
    key    = {it.net, it.comp, it.term};
    r      = '0;
    r.last = 1'b1;
    case (it.cmd)
      usc_pkg::CMD_INSERT: begin
        dup = 1'b0;
        pos = held_keys.size();
        foreach (held_keys[i]) begin
          if (held_keys[i] == key) dup = 1'b1;
          if (held_keys[i] > key && pos == held_keys.size()) pos = i;
        end
        // Duplicate check wins over the full check.
        if (dup) begin
          r.status = usc_pkg::STAT_DUPLICATE;
        end else if (held_keys.size() >= usc_pkg::CAPACITY) begin
          r.status = usc_pkg::STAT_FULL;
        end else begin
          held_keys.insert(pos, key);
          r.status = usc_pkg::STAT_INSERTED;
        end
        expected_results.push_back(r);
      end
      usc_pkg::CMD_EMIT: begin
        if (held_keys.size() == 0) begin
          r.status = usc_pkg::STAT_EMPTY;
          expected_results.push_back(r);
        end else begin
          foreach (held_keys[i]) begin
            r.status = usc_pkg::STAT_EMITTED;
            r.net    = held_keys[i][usc_pkg::KEY_W-1 -: usc_pkg::NET_W];
            r.comp   = held_keys[i][usc_pkg::TERM_W +: usc_pkg::COMP_W];
            r.term   = held_keys[i][usc_pkg::TERM_W-1:0];
            r.last   = (i == held_keys.size() - 1);
            expected_results.push_back(r);
          end
        end
      end
      usc_pkg::CMD_CLEAR: begin
        held_keys.delete();
        r.status = usc_pkg::STAT_CLEARED;
        expected_results.push_back(r);
      end
      default: ;  // unused code: no result, set untouched
    endcase
  endfunction

  function automatic void push_item(logic [usc_pkg::CMD_W-1:0] cmd,
                                    logic [usc_pkg::KEY_W-1:0] key);
    conn_item_t it;
    it.cmd  = cmd;
    it.net  = key[usc_pkg::KEY_W-1 -: usc_pkg::NET_W];
    it.comp = key[usc_pkg::TERM_W +: usc_pkg::COMP_W];
    it.term = key[usc_pkg::TERM_W-1:0];
    pending_items.push_back(it);
    if (cmd == usc_pkg::CMD_INSERT) used_keys.push_back(key);
  endfunction

  function automatic logic [usc_pkg::KEY_W-1:0] wide_key();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[usc_pkg::KEY_W-1:0];
  endfunction

  // Mix of reused keys (duplicates), clustered keys (ties on the upper key
  // parts, so the lower parts decide the order) and fully random keys.
  function automatic logic [usc_pkg::KEY_W-1:0] draw_key();
    case ($urandom_range(0, 3))
      0: begin
        if (used_keys.size() > 0) begin
          return used_keys[$urandom_range(0, used_keys.size() - 1)];
        end
        return wide_key();
      end
      1: return {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                 8'($urandom_range(8'h41, 8'h5a))};
      default: return wide_key();
    endcase
  endfunction

  // Sender: a new transaction goes out at a falling edge once the previous
  // one was taken and its drawn gap has run out.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        driven_item = pending_items.pop_front();
        s_tdata  <= {6'b0, driven_item.term, driven_item.comp, driven_item.net,
                     driven_item.cmd};
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Input transaction accepted: predict its results right away.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_set_update(driven_item);
      items_accepted++;
      in_taken = 1'b1;
    end
  end

  // Receiver: after each result, hold tready low for a drawn number of cycles.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Output checker: each result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      out_taken   = 1'b1;
      got.status  = usc_pkg::status_t'(m_tdata[2:0]);
      got.net     = m_tdata[18:3];
      got.comp    = m_tdata[34:19];
      got.term    = m_tdata[42:35];
      got.last    = m_tlast;
      if (expected_results.size() == 0) begin
        faults++;
        if (reported < REPORT_LIMIT) begin
          $display("%0t: unexpected result status=%0d net=%h comp=%h term=%h last=%b",
                   $realtime, got.status, got.net, got.comp, got.term, got.last);
        end
        reported++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.status !== want.status || got.net !== want.net ||
            got.comp !== want.comp || got.term !== want.term ||
            got.last !== want.last) begin
          faults++;
          if (reported < REPORT_LIMIT) begin
            $display("%0t: result %0d mismatch: expected status=%0d net=%h comp=%h",
                     $realtime, results_checked, want.status, want.net, want.comp);
            $display("%0t:   expected term=%h last=%b",
                     $realtime, want.term, want.last);
            $display("%0t:   actual status=%0d net=%h comp=%h term=%h last=%b",
                     $realtime, got.status, got.net, got.comp, got.term, got.last);
          end
          reported++;
        end else begin
          status_hits[want.status]++;
        end
      end
    end
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb_unique_connection_sorted_set: FAIL");
    $finish;
  end

  initial begin
    logic [usc_pkg::KEY_W-1:0] fill_keys[$];
    logic [usc_pkg::KEY_W-1:0] key;
    int                        fresh;
    int                        n;

    // Directed part: empty emit, key extremes, duplicates, ordering on
    // every key part, ignored operands on emit and clear, the unused code.
    push_item(usc_pkg::CMD_EMIT,   wide_key());
    push_item(usc_pkg::CMD_INSERT, {16'hffff, 16'hffff, 8'hff});
    push_item(usc_pkg::CMD_INSERT, {16'h0000, 16'h0000, 8'h00});
    push_item(usc_pkg::CMD_INSERT, {16'h0000, 16'h0000, 8'h00});
    push_item(usc_pkg::CMD_INSERT, {16'h0001, 16'h0000, 8'h44});
    push_item(usc_pkg::CMD_INSERT, {16'h0000, 16'hffff, 8'h53});
    push_item(usc_pkg::CMD_INSERT, {16'h0000, 16'h0000, 8'hff});
    push_item(usc_pkg::CMD_INSERT, {16'haaaa, 16'h5555, 8'ha5});
    push_item(usc_pkg::CMD_INSERT, {16'h5555, 16'haaaa, 8'h5a});
    push_item(usc_pkg::CMD_EMIT,   {16'hffff, 16'hffff, 8'hff});
    push_item(CMD_UNUSED,          wide_key());
    push_item(usc_pkg::CMD_INSERT, {16'hffff, 16'hffff, 8'hff});
    push_item(CMD_UNUSED,          {16'hffff, 16'hffff, 8'hff});
    push_item(usc_pkg::CMD_EMIT,   wide_key());
    push_item(usc_pkg::CMD_CLEAR,  {16'hffff, 16'hffff, 8'hff});
    push_item(usc_pkg::CMD_EMIT,   '0);
    push_item(usc_pkg::CMD_CLEAR,  wide_key());
    push_item(usc_pkg::CMD_INSERT, {16'h0000, 16'h0000, 8'h44});
    push_item(usc_pkg::CMD_EMIT,   wide_key());

    // Fill to capacity, then a duplicate on the full table (duplicate wins),
    // two new keys (dropped as full), a full emit and a clear.
    push_item(usc_pkg::CMD_CLEAR, wide_key());
    while (fill_keys.size() < usc_pkg::CAPACITY) begin
      key   = draw_key();
      fresh = 1;
      foreach (fill_keys[i]) if (fill_keys[i] == key) fresh = 0;
      if (fresh) begin
        fill_keys.push_back(key);
        push_item(usc_pkg::CMD_INSERT, key);
      end
    end
    push_item(usc_pkg::CMD_INSERT, fill_keys[$urandom_range(0, usc_pkg::CAPACITY - 1)]);
    push_item(usc_pkg::CMD_INSERT, wide_key());
    push_item(usc_pkg::CMD_INSERT, wide_key());
    push_item(usc_pkg::CMD_EMIT,   wide_key());
    push_item(usc_pkg::CMD_CLEAR,  wide_key());

    // Random part: mostly insert batches closed by an emit; some noise with
    // every code, some empty-table emits.
    while (pending_items.size() < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          n = $urandom_range(1, 4);
          repeat (n) push_item(usc_pkg::CMD_W'($urandom_range(0, 3)), wide_key());
        end
        9: begin
          push_item(usc_pkg::CMD_CLEAR, wide_key());
          push_item(usc_pkg::CMD_EMIT,  wide_key());
        end
        default: begin
          if ($urandom_range(0, 1)) push_item(usc_pkg::CMD_CLEAR, wide_key());
          n = $urandom_range(1, 10);
          repeat (n) push_item(usc_pkg::CMD_INSERT, draw_key());
          push_item(usc_pkg::CMD_EMIT, wide_key());
        end
      endcase
    end
    items_total = pending_items.size();

    // Hold reset, then release it on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    // Then keep the clock running to catch any stray result.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transactions and %0d checked results.",
             items_accepted, results_checked);
    $display("Statuses seen: inserted %0d, duplicate %0d, full %0d,",
             status_hits[usc_pkg::STAT_INSERTED], status_hits[usc_pkg::STAT_DUPLICATE],
             status_hits[usc_pkg::STAT_FULL]);
    $display("  emitted %0d, empty %0d, cleared %0d",
             status_hits[usc_pkg::STAT_EMITTED], status_hits[usc_pkg::STAT_EMPTY],
             status_hits[usc_pkg::STAT_CLEARED]);
    if (faults == 0 && expected_results.size() == 0) begin
      $display("tb_unique_connection_sorted_set: PASS");
    end else begin
      $display("tb_unique_connection_sorted_set: FAIL");
    end
    $finish;
  end

endmodule
